// ===== src/hsv_to_rgb_warm_pixel_macros.svh =====
// Assertion macros shared by the pixel converter.
// Each macro needs a signal named clk in the scope where it is used; HSVW_ASSERT also needs rst.
`ifndef HSV_TO_RGB_WARM_PIXEL_MACROS_SVH
`define HSV_TO_RGB_WARM_PIXEL_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define HSVW_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hsvw check failed");
// Check a property on every rising edge, reset included.
`define HSVW_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hsvw check failed");
`else
`define HSVW_ASSERT(label, prop)
`define HSVW_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== src/hsvw_pkg.sv =====
`timescale 1ns / 1ps
package hsvw_pkg;

  // Hue regions of the six-region scheme
  typedef enum logic [2:0] {
    RGN_0 = 3'd0,
    RGN_1 = 3'd1,
    RGN_2 = 3'd2,
    RGN_3 = 3'd3,
    RGN_4 = 3'd4,
    RGN_5 = 3'd5
  } region_t;

  localparam logic [7:0] HUE_SPAN   = 8'd43;
  localparam logic [7:0] FULL_LEVEL = 8'd255;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GREEN_GAIN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLUE_GAIN  = 2'd1;

  localparam logic [6:0] GREEN_GAIN_RESET = 7'd85;
  localparam logic [6:0] BLUE_GAIN_RESET  = 7'd40;

  // Reciprocal of 100: x * 5243 >> 19 is exact for x below 43690
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;

  // Region and scaled remainder
  typedef struct packed {
    logic       valid;
    region_t    region;
    logic [7:0] rem;
    logic [7:0] sat;
    logic [7:0] val;
  } split_t;

  // Saturation products and p term
  typedef struct packed {
    logic       valid;
    region_t    region;
    logic [7:0] sr;
    logic [7:0] srt;
    logic [7:0] p;
    logic [7:0] val;
  } prod_t;

  // All three terms
  typedef struct packed {
    logic       valid;
    region_t    region;
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] t;
    logic [7:0] val;
  } terms_t;

endpackage

// ===== src/hsv_to_rgb_warm_pixel.sv =====
`timescale 1ns / 1ps
// Warm-tinted HSV to RGB pixel converter.
// Input: drive hue, saturation and brightness with start high; a transaction
// is taken at every rising edge where start is high and busy is low. busy
// stays low, so a new pixel may enter on every clock cycle.
// Output: red, green and blue are valid for one cycle while done is high,
// once the input transaction has passed every pipeline register. Results
// leave in input order. Throughput is one pixel per cycle; the pipeline
// stages are hue split, saturation products, value products, region select
// with gain multiply, and the divide-by-100 reciprocal multiply with clamp.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. Index 0 is
// the green gain, index 1 the blue gain, in percent; other indexes are
// ignored. cfg_ready is always high. Write gains only while no pixel is in
// flight.
// Reset: synchronous rst clears the pipeline valid bits and restores the
// gains to 85 (green) and 40 (blue). The receiver cannot stall, so no
// backpressure exists past the output register.
`include "hsv_to_rgb_warm_pixel_macros.svh"
module hsv_to_rgb_warm_pixel (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [7:0]                       hue,
  input  logic [7:0]                       saturation,
  input  logic [7:0]                       brightness,
  output logic                             done,
  output logic [7:0]                       red,
  output logic [7:0]                       green,
  output logic [7:0]                       blue,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hsvw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [6:0]                       cfg_data
);

  logic             accept;
  logic [6:0]       green_gain;
  logic [6:0]       blue_gain;
  hsvw_pkg::split_t split;
  hsvw_pkg::terms_t terms;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Hold the gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      green_gain <= hsvw_pkg::GREEN_GAIN_RESET;
      blue_gain  <= hsvw_pkg::BLUE_GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == hsvw_pkg::CFG_GREEN_GAIN) begin
        green_gain <= cfg_data;
      end
      if (cfg_index == hsvw_pkg::CFG_BLUE_GAIN) begin
        blue_gain <= cfg_data;
      end
    end
  end

  hsvw_hue_split u_split (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .split      (split)
  );

  hsvw_terms u_terms (
    .clk   (clk),
    .rst   (rst),
    .split (split),
    .terms (terms)
  );

  hsvw_gain u_gain (
    .clk        (clk),
    .rst        (rst),
    .terms      (terms),
    .green_gain (green_gain),
    .blue_gain  (blue_gain),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  // Every transaction comes out once it has passed every pipeline stage
  `HSVW_ASSERT(a_latency, accept |-> ##5 done)
  // No result without a matching earlier transaction
  `HSVW_ASSERT(a_no_phantom, done |-> $past(accept, 5))
  // Zero green gain blanks the green channel
  `HSVW_ASSERT(a_zero_green, (done && green_gain == 7'd0) |-> green == 8'd0)
  // Reset empties the pipeline
  `HSVW_ASSERT_ALWAYS(a_reset_flush, rst |=> !done && !split.valid)

endmodule

// ===== src/hsvw_hue_split.sv =====
`timescale 1ns / 1ps
module hsvw_hue_split (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      hue,
  input  logic [7:0]      saturation,
  input  logic [7:0]      brightness,
  output hsvw_pkg::split_t split
);

  hsvw_pkg::region_t region_next;
  logic [7:0]        base;
  logic [7:0]        offset;
  logic [7:0]        rem_next;

  // Find the region by comparing against multiples of the span
  always_comb begin
    if (hue >= 8'(5 * hsvw_pkg::HUE_SPAN)) begin
      region_next = hsvw_pkg::RGN_5;
      base = 8'(5 * hsvw_pkg::HUE_SPAN);
    end else if (hue >= 8'(4 * hsvw_pkg::HUE_SPAN)) begin
      region_next = hsvw_pkg::RGN_4;
      base = 8'(4 * hsvw_pkg::HUE_SPAN);
    end else if (hue >= 8'(3 * hsvw_pkg::HUE_SPAN)) begin
      region_next = hsvw_pkg::RGN_3;
      base = 8'(3 * hsvw_pkg::HUE_SPAN);
    end else if (hue >= 8'(2 * hsvw_pkg::HUE_SPAN)) begin
      region_next = hsvw_pkg::RGN_2;
      base = 8'(2 * hsvw_pkg::HUE_SPAN);
    end else if (hue >= hsvw_pkg::HUE_SPAN) begin
      region_next = hsvw_pkg::RGN_1;
      base = hsvw_pkg::HUE_SPAN;
    end else begin
      region_next = hsvw_pkg::RGN_0;
      base = 8'd0;
    end
    offset = hue - base;
    // Scale the remainder by six as 4x + 2x, kept to a byte
    rem_next = {offset[5:0], 2'b00} + {offset[6:0], 1'b0};
  end

  // Register the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      split.valid <= 1'b0;
    end else begin
      split.valid <= accept;
    end
    split.region <= region_next;
    split.rem    <= rem_next;
    split.sat    <= saturation;
    split.val    <= brightness;
  end

endmodule

// ===== src/hsvw_terms.sv =====
`timescale 1ns / 1ps
module hsvw_terms (
  input  logic             clk,
  input  logic             rst,
  input  hsvw_pkg::split_t split,
  output hsvw_pkg::terms_t terms
);

  hsvw_pkg::prod_t prod;
  logic [15:0] sr_full;
  logic [15:0] srt_full;
  logic [15:0] p_full;
  logic [15:0] q_full;
  logic [15:0] t_full;

  // Saturation products and the p term
  assign sr_full  = 16'(split.sat) * 16'(split.rem);
  assign srt_full = 16'(split.sat) * 16'(hsvw_pkg::FULL_LEVEL - split.rem);
  assign p_full   = 16'(split.val) * 16'(hsvw_pkg::FULL_LEVEL - split.sat);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod.valid <= 1'b0;
    end else begin
      prod.valid <= split.valid;
    end
    prod.region <= split.region;
    prod.sr     <= sr_full[15:8];
    prod.srt    <= srt_full[15:8];
    prod.p      <= p_full[15:8];
    prod.val    <= split.val;
  end

  // Value products for q and t
  assign q_full = 16'(prod.val) * 16'(hsvw_pkg::FULL_LEVEL - prod.sr);
  assign t_full = 16'(prod.val) * 16'(hsvw_pkg::FULL_LEVEL - prod.srt);

  always_ff @(posedge clk) begin
    if (rst) begin
      terms.valid <= 1'b0;
    end else begin
      terms.valid <= prod.valid;
    end
    terms.region <= prod.region;
    terms.p      <= prod.p;
    terms.q      <= q_full[15:8];
    terms.t      <= t_full[15:8];
    terms.val    <= prod.val;
  end

endmodule

// ===== src/hsvw_gain.sv =====
`timescale 1ns / 1ps
module hsvw_gain (
  input  logic             clk,
  input  logic             rst,
  input  hsvw_pkg::terms_t terms,
  input  logic [6:0]       green_gain,
  input  logic [6:0]       blue_gain,
  output logic             done,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue
);

  logic [7:0]  r_sel;
  logic [7:0]  g_sel;
  logic [7:0]  b_sel;
  logic        mix_valid;
  logic [7:0]  mix_red;
  logic [14:0] mix_green;
  logic [14:0] mix_blue;
  logic [27:0] g_recip;
  logic [27:0] b_recip;
  logic [8:0]  g_quot;
  logic [8:0]  b_quot;

  // Pick the channel order of the region
  always_comb begin
    case (terms.region)
      hsvw_pkg::RGN_0: begin r_sel = terms.val; g_sel = terms.t;   b_sel = terms.p;   end
      hsvw_pkg::RGN_1: begin r_sel = terms.q;   g_sel = terms.val; b_sel = terms.p;   end
      hsvw_pkg::RGN_2: begin r_sel = terms.p;   g_sel = terms.val; b_sel = terms.t;   end
      hsvw_pkg::RGN_3: begin r_sel = terms.p;   g_sel = terms.q;   b_sel = terms.val; end
      hsvw_pkg::RGN_4: begin r_sel = terms.t;   g_sel = terms.p;   b_sel = terms.val; end
      default:         begin r_sel = terms.val; g_sel = terms.p;   b_sel = terms.q;   end
    endcase
  end

  // Apply the percentage gains
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
    end else begin
      mix_valid <= terms.valid;
    end
    mix_red   <= r_sel;
    mix_green <= 15'(g_sel) * 15'(green_gain);
    mix_blue  <= 15'(b_sel) * 15'(blue_gain);
  end

  // Divide by one hundred through the reciprocal, then clamp to a byte
  assign g_recip = 28'(mix_green) * 28'(hsvw_pkg::RECIP_100);
  assign b_recip = 28'(mix_blue) * 28'(hsvw_pkg::RECIP_100);
  assign g_quot  = g_recip[hsvw_pkg::RECIP_SHIFT +: 9];
  assign b_quot  = b_recip[hsvw_pkg::RECIP_SHIFT +: 9];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mix_valid;
    end
    red   <= mix_red;
    green <= g_quot[8] ? hsvw_pkg::FULL_LEVEL : g_quot[7:0];
    blue  <= b_quot[8] ? hsvw_pkg::FULL_LEVEL : b_quot[7:0];
  end

endmodule

// ===== bench/hsv_to_rgb_warm_pixel_tb.sv =====
`timescale 1ns / 1ps
module hsv_to_rgb_warm_pixel_tb;

  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned PIPE_SLACK    = 8;
  localparam int unsigned PHASE_PIXELS  = 325;
  localparam int unsigned REPORT_LIMIT  = 10;
  // Indexes outside the register map; the block must ignore these writes
  localparam logic [hsvw_pkg::CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [hsvw_pkg::CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Tracks the gain registers and the queue of predicted pixels
  class rgb_scoreboard;
    logic [6:0] green_gain;
    logic [6:0] blue_gain;
    rgb_t       pending_rgb[$];
    int         mismatches;

    function new();
      green_gain  = hsvw_pkg::GREEN_GAIN_RESET;
      blue_gain   = hsvw_pkg::BLUE_GAIN_RESET;
      mismatches  = 0;
    endfunction

    function void write_gain(logic [hsvw_pkg::CFG_INDEX_W-1:0] index, logic [6:0] data);
      case (index)
        hsvw_pkg::CFG_GREEN_GAIN: green_gain = data;
        hsvw_pkg::CFG_BLUE_GAIN:  blue_gain  = data;
        default: ;
      endcase
    endfunction

    // Percent gain with truncating divide, clamped to full level
    function logic [7:0] scale_level(logic [7:0] level, logic [6:0] gain);
      int unsigned scaled;
      scaled = (int'(level) * int'(gain)) / 100;
      return (scaled > 255) ? hsvw_pkg::FULL_LEVEL : 8'(scaled);
    endfunction

    function rgb_t convert(logic [7:0] h, logic [7:0] s, logic [7:0] v);
      hsvw_pkg::region_t region;
      int unsigned       rem;
      int unsigned       p_term;
      int unsigned       q_term;
      int unsigned       t_term;
      int unsigned       r_lvl;
      int unsigned       g_lvl;
      int unsigned       b_lvl;
      rgb_t              pix;
      region = hsvw_pkg::region_t'(int'(h) / int'(hsvw_pkg::HUE_SPAN));
      rem    = ((int'(h) - int'(region) * int'(hsvw_pkg::HUE_SPAN)) * 6) & 8'hFF;
      p_term = (int'(v) * (255 - int'(s))) >> 8;
      q_term = (int'(v) * (255 - ((int'(s) * rem) >> 8))) >> 8;
      t_term = (int'(v) * (255 - ((int'(s) * (255 - rem)) >> 8))) >> 8;
      // Pick the channel ordering of the hue region
      case (region)
        hsvw_pkg::RGN_0: begin r_lvl = 32'(v); g_lvl = t_term; b_lvl = p_term; end
        hsvw_pkg::RGN_1: begin r_lvl = q_term; g_lvl = 32'(v); b_lvl = p_term; end
        hsvw_pkg::RGN_2: begin r_lvl = p_term; g_lvl = 32'(v); b_lvl = t_term; end
        hsvw_pkg::RGN_3: begin r_lvl = p_term; g_lvl = q_term; b_lvl = 32'(v); end
        hsvw_pkg::RGN_4: begin r_lvl = t_term; g_lvl = p_term; b_lvl = 32'(v); end
        default:         begin r_lvl = 32'(v); g_lvl = p_term; b_lvl = q_term; end
      endcase
      pix.red   = 8'(r_lvl);
      pix.green = scale_level(8'(g_lvl), green_gain);
      pix.blue  = scale_level(8'(b_lvl), blue_gain);
      return pix;
    endfunction

    function void note_pixel(logic [7:0] h, logic [7:0] s, logic [7:0] v);
      pending_rgb.push_back(convert(h, s, v));
    endfunction

    function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      rgb_t want;
      if (pending_rgb.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] unexpected pixel r=%0d g=%0d b=%0d", $realtime, r, g, b);
        return;
      end
      want = pending_rgb.pop_front();
      if (want.red !== r || want.green !== g || want.blue !== b) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   $realtime, want.red, want.green, want.blue, r, g, b);
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             start;
  logic                             busy;
  logic [7:0]                       hue;
  logic [7:0]                       saturation;
  logic [7:0]                       brightness;
  logic                             done;
  logic [7:0]                       red;
  logic [7:0]                       green;
  logic [7:0]                       blue;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [hsvw_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [6:0]                       cfg_data;

  rgb_scoreboard sb = new();
  int unsigned   quiet_cycles = 0;

  hsv_to_rgb_warm_pixel i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Check every pixel leaving the block
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result(red, green, blue);
  end

  // Count cycles in which no transaction of any kind happens
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Offer one pixel, idling first with the given chance per cycle
  task automatic send_pixel(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v,
                            input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start      <= 1'b1;
    hue        <= h;
    saturation <= s;
    brightness <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_pixel(h, s, v);
  endtask

  // Hold off the sender until every predicted pixel has come back
  task automatic drain_pixels();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_rgb.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  task automatic write_gain_reg(input logic [hsvw_pkg::CFG_INDEX_W-1:0] index,
                                input logic [6:0] data);
    drain_pixels();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_gain(index, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly uniform, with extra weight on the ends of the range
  function automatic logic [7:0] pick_level();
    if ($urandom_range(7) == 0)
      return $urandom_range(1) ? 8'd255 : 8'd0;
    return 8'($urandom_range(255));
  endfunction

  initial begin
    logic [7:0]  directed_hsv[20][3];
    int unsigned idle_pct[3];
    logic [6:0]  g_gain;
    logic [6:0]  b_gain;
    directed_hsv = '{
      '{8'd0,   8'd255, 8'd255}, '{8'd42,  8'd255, 8'd255}, '{8'd43,  8'd255, 8'd255},
      '{8'd85,  8'd255, 8'd255}, '{8'd86,  8'd255, 8'd255}, '{8'd128, 8'd255, 8'd255},
      '{8'd129, 8'd255, 8'd255}, '{8'd171, 8'd255, 8'd255}, '{8'd172, 8'd255, 8'd255},
      '{8'd214, 8'd255, 8'd255}, '{8'd215, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255},
      '{8'd0,   8'd0,   8'd255}, '{8'd128, 8'd0,   8'd255}, '{8'd255, 8'd0,   8'd0},
      '{8'd0,   8'd0,   8'd0},   '{8'd100, 8'd128, 8'd200}, '{8'd30,  8'd255, 8'd128},
      '{8'd250, 8'd1,   8'd254}, '{8'd170, 8'd254, 8'd1}
    };
    idle_pct = '{0, 84, 28};
    rst        = 1'b1;
    start      = 1'b0;
    hue        = '0;
    saturation = '0;
    brightness = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Region edges and field extremes at the reset gains, back to back
    foreach (directed_hsv[i])
      send_pixel(directed_hsv[i][0], directed_hsv[i][1], directed_hsv[i][2], 0);

    // Random pixels under a sequence of gain settings and idle rates
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin g_gain = 7'd100; b_gain = 7'd100; end
        1: begin g_gain = 7'd0;   b_gain = 7'd0;   end
        2: begin g_gain = 7'd127; b_gain = 7'd127; end
        3: begin g_gain = 7'd101; b_gain = 7'd1;   end
        default: begin
          g_gain = 7'($urandom_range(127));
          b_gain = 7'($urandom_range(127));
        end
      endcase
      write_gain_reg(hsvw_pkg::CFG_GREEN_GAIN, g_gain);
      write_gain_reg(hsvw_pkg::CFG_BLUE_GAIN, b_gain);
      if (ph == 3) begin
        write_gain_reg(CFG_SPARE_2, 7'd127);
        write_gain_reg(CFG_SPARE_3, 7'd0);
      end
      repeat (PHASE_PIXELS) begin
        send_pixel(pick_level(), pick_level(), pick_level(), idle_pct[ph % 3]);
        if ($urandom_range(149) == 0)
          drain_pixels();
      end
    end

    drain_pixels();
    repeat (PIPE_SLACK) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_rgb.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
